>>> rtl/core/ahs_pkg.sv
// ----------------------------------------------------------------------------
// Access hazard scoreboard package
// Shared sizes, codes and record types of the access hazard scoreboard.
// ----------------------------------------------------------------------------
package ahs_pkg;

	localparam int TYPE_COUNT   = 64;
	localparam int TYPE_W       = $clog2(TYPE_COUNT);
	localparam int READER_SLOTS = 8;
	localparam int SLOT_W       = (READER_SLOTS > 1) ? $clog2(READER_SLOTS) : 1;
	localparam int RCNT_W       = $clog2(READER_SLOTS + 1);
	localparam int READ_SLOTS   = 16;
	localparam int PIDX_W       = (READ_SLOTS > 1) ? $clog2(READ_SLOTS) : 1;
	localparam int PCNT_W       = $clog2(READ_SLOTS + 1);

	// Request kinds.
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// Hazard codes.
	localparam logic [1:0] HAZ_RAW = 2'd0;
	localparam logic [1:0] HAZ_WAR = 2'd1;
	localparam logic [1:0] HAZ_WAW = 2'd2;

	// One recorded access: task, random mode and dispatch mode.
	typedef struct packed {
		logic [7:0] task_id;
		logic       rnd;
		logic       disp;
	} acc_t;

	localparam int ACC_W = $bits(acc_t);

	// One result without its last marker.
	typedef struct packed {
		logic [7:0] depends_on;
		logic       whole_task_sync;
		logic [1:0] hazard;
		logic       is_summary;
		logic       self_conflict;
		logic       reader_overflow;
	} res_t;

	// A remembered read of the current task: its type and random mode.
	typedef struct packed {
		logic [TYPE_W-1:0] type_id;
		logic              rnd;
	} pend_t;

	localparam int PEND_W = $bits(pend_t);

endpackage

>>> rtl/core/access_hazard_scoreboard.sv
// ----------------------------------------------------------------------------
// Access hazard scoreboard
// Tracks last writer and readers per resource type and reports dependencies.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Read requests give a
// read-after-write dependency; write requests give write-after-read
// dependencies on the other readers and a write-after-write dependency on the
// last writer. A final access adds a summary with the task's flags. A clear
// request empties the table and gives no result.
// Each result is shown for one cycle with result_valid high; last marks the
// final result of a request. The receiver cannot stall the block.
// A clear or an unused kind is taken while idle and busy never rises. A read
// keeps busy high through LOOKUP, FINISH and FLUSH. A write keeps busy high
// through LOOKUP, a scan of the task's remembered reads (P, up to 16), a scan
// of the type's readers (R, up to 8), FINISH and FLUSH. One memory port per
// list is read one entry a cycle. The final result is shown in the first
// cycle with busy low again. Reset empties the table at once.
// ----------------------------------------------------------------------------
module access_hazard_scoreboard
	import ahs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] kind,
	input  logic [7:0] task_id,
	input  logic [5:0] type_id,
	input  logic       random_access,
	input  logic       task_random_dispatch,
	input  logic       last_access,
	output logic       result_valid,
	output logic [7:0] depends_on,
	output logic       whole_task_sync,
	output logic [1:0] hazard,
	output logic       is_summary,
	output logic       self_conflict,
	output logic       reader_overflow,
	output logic       last
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOOKUP = 3'd1;
	localparam logic [2:0] ST_PSCAN  = 3'd2;
	localparam logic [2:0] ST_RSCAN  = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;
	localparam logic [2:0] ST_FLUSH  = 3'd5;

	logic [2:0]            state_q;
	logic [1:0]            kind_q;
	acc_t                  cur_q;
	logic [TYPE_W-1:0]     ty_q;
	logic                  fin_q;
	logic [TYPE_COUNT-1:0] wvalid_q;
	logic [TYPE_COUNT-1:0] rcvalid_q;
	logic                  wv_q;
	acc_t                  went_q;
	logic [RCNT_W-1:0]     rcnt_q;
	logic [PCNT_W-1:0]     pcnt_q;
	logic [PCNT_W-1:0]     pidx_q;
	logic [RCNT_W-1:0]     ridx_q;
	logic                  chk_q;
	logic                  conflict_q;
	logic                  overflow_q;
	logic                  hold_v_q;
	res_t                  hold_q;
	res_t                  out_q;
	logic                  out_v_q;
	logic                  out_last_q;

	// Memory ports.
	logic                           w_we, w_re;
	acc_t                           w_rdata;
	logic                           rc_we, rc_re;
	logic [RCNT_W-1:0]              rc_wdata, rc_rdata;
	logic                           re_we, re_re;
	logic [TYPE_W+SLOT_W-1:0]       re_waddr, re_raddr;
	acc_t                           re_rdata;
	logic                           p_we, p_re;
	pend_t                          p_wdata, p_rdata;
	logic [TYPE_W-1:0]              ty_rd;

	// Sequencer decisions.
	logic                           push_v;
	res_t                           push_r;
	logic [RCNT_W-1:0]              rcnt_l;
	logic                           p_more, r_more;
	logic [2:0]                     state_d;

	assign ty_rd  = type_id[TYPE_W-1:0];
	assign rcnt_l = rcvalid_q[ty_q] ? rc_rdata : '0;
	assign p_more = (pidx_q < pcnt_q);
	assign r_more = (ridx_q < rcnt_q);

	ahs_ram #(.DEPTH(TYPE_COUNT), .WIDTH(ACC_W)) u_writer (
		.clk(clk), .we(w_we), .waddr(ty_q), .wdata(cur_q),
		.re(w_re), .raddr(ty_rd), .rdata(w_rdata)
	);

	ahs_ram #(.DEPTH(TYPE_COUNT), .WIDTH(RCNT_W)) u_rcount (
		.clk(clk), .we(rc_we), .waddr(ty_q), .wdata(rc_wdata),
		.re(rc_re), .raddr(ty_rd), .rdata(rc_rdata)
	);

	ahs_ram #(.DEPTH(TYPE_COUNT * READER_SLOTS), .WIDTH(ACC_W)) u_readers (
		.clk(clk), .we(re_we), .waddr(re_waddr), .wdata(cur_q),
		.re(re_re), .raddr(re_raddr), .rdata(re_rdata)
	);

	ahs_ram #(.DEPTH(READ_SLOTS), .WIDTH(PEND_W)) u_pending (
		.clk(clk), .we(p_we), .waddr(pcnt_q[PIDX_W-1:0]), .wdata(p_wdata),
		.re(p_re), .raddr(pidx_q[PIDX_W-1:0]), .rdata(p_rdata)
	);

	// Sequencer control and result generation.
	always_comb begin
		state_d   = state_q;
		push_v    = 1'b0;
		push_r    = '0;
		w_we      = 1'b0;
		w_re      = 1'b0;
		rc_we     = 1'b0;
		rc_re     = 1'b0;
		rc_wdata  = rcnt_l + 1'b1;
		re_we     = 1'b0;
		re_re     = 1'b0;
		re_waddr  = {ty_q, rcnt_l[SLOT_W-1:0]};
		re_raddr  = {ty_q, ridx_q[SLOT_W-1:0]};
		p_we      = 1'b0;
		p_re      = 1'b0;
		p_wdata   = '{type_id: ty_q, rnd: cur_q.rnd};
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					w_re  = 1'b1;
					rc_re = 1'b1;
					if (kind inside {KIND_READ, KIND_WRITE}) begin
						state_d = ST_LOOKUP;
					end
				end
			end
			ST_LOOKUP: begin
				if (kind_q == KIND_READ) begin
					if (wvalid_q[ty_q]) begin
						push_v = 1'b1;
						push_r.depends_on = w_rdata.task_id;
						push_r.whole_task_sync = cur_q.rnd | cur_q.disp |
							w_rdata.rnd | w_rdata.disp;
						push_r.hazard = HAZ_RAW;
					end
					if (rcnt_l < RCNT_W'(READER_SLOTS)) begin
						re_we = 1'b1;
						rc_we = 1'b1;
					end
					if (pcnt_q < PCNT_W'(READ_SLOTS)) begin
						p_we = 1'b1;
					end
					state_d = ST_FINISH;
				end else begin
					state_d = ST_PSCAN;
				end
			end
			ST_PSCAN: begin
				p_re = p_more;
				if (!p_more && !chk_q) begin
					state_d = ST_RSCAN;
				end
			end
			ST_RSCAN: begin
				re_re = r_more;
				if (chk_q && re_rdata.task_id != cur_q.task_id) begin
					push_v = 1'b1;
					push_r.depends_on = re_rdata.task_id;
					push_r.whole_task_sync = cur_q.rnd | cur_q.disp |
						re_rdata.rnd | re_rdata.disp;
					push_r.hazard = HAZ_WAR;
				end
				if (!r_more && !chk_q) begin
					if (wv_q) begin
						push_v = 1'b1;
						push_r.depends_on = went_q.task_id;
						push_r.whole_task_sync = cur_q.rnd | cur_q.disp |
							went_q.rnd | went_q.disp;
						push_r.hazard = HAZ_WAW;
					end
					w_we    = 1'b1;
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (fin_q) begin
					push_v = 1'b1;
					push_r.is_summary = 1'b1;
					push_r.self_conflict = conflict_q;
					push_r.reader_overflow = overflow_q;
				end
				state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer state, table flags and task flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wvalid_q   <= '0;
			rcvalid_q  <= '0;
			pcnt_q     <= '0;
			conflict_q <= 1'b0;
			overflow_q <= 1'b0;
			chk_q      <= 1'b0;
			pidx_q     <= '0;
			ridx_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					pidx_q <= '0;
					ridx_q <= '0;
					chk_q  <= 1'b0;
					if (start && kind == KIND_CLEAR) begin
						wvalid_q   <= '0;
						rcvalid_q  <= '0;
						pcnt_q     <= '0;
						conflict_q <= 1'b0;
						overflow_q <= 1'b0;
					end
				end
				ST_LOOKUP: begin
					if (kind_q == KIND_READ) begin
						if (rcnt_l < RCNT_W'(READER_SLOTS)) begin
							rcvalid_q[ty_q] <= 1'b1;
						end else begin
							overflow_q <= 1'b1;
						end
						if (pcnt_q < PCNT_W'(READ_SLOTS)) begin
							pcnt_q <= pcnt_q + 1'b1;
						end else begin
							overflow_q <= 1'b1;
						end
					end
				end
				ST_PSCAN: begin
					chk_q <= p_more;
					if (p_more) begin
						pidx_q <= pidx_q + 1'b1;
					end
					if (chk_q && p_rdata.type_id == ty_q && (p_rdata.rnd || cur_q.rnd)) begin
						conflict_q <= 1'b1;
					end
				end
				ST_RSCAN: begin
					chk_q <= r_more;
					if (r_more) begin
						ridx_q <= ridx_q + 1'b1;
					end
					if (!r_more && !chk_q) begin
						wvalid_q[ty_q]  <= 1'b1;
						rcvalid_q[ty_q] <= 1'b0;
					end
				end
				ST_FINISH: begin
					if (fin_q) begin
						pcnt_q     <= '0;
						conflict_q <= 1'b0;
						overflow_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Request capture and table lookups.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			kind_q <= kind;
			cur_q  <= '{task_id: task_id, rnd: random_access, disp: task_random_dispatch};
			ty_q   <= ty_rd;
			fin_q  <= last_access;
		end
		if (state_q == ST_LOOKUP) begin
			wv_q   <= wvalid_q[ty_q];
			went_q <= w_rdata;
			rcnt_q <= rcnt_l;
		end
	end

	// One result is held back so that the final one can carry its marker.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
			if (push_v) begin
				hold_v_q <= 1'b1;
				if (hold_v_q) begin
					out_v_q <= 1'b1;
				end
			end else if (state_q == ST_FLUSH && hold_v_q) begin
				hold_v_q   <= 1'b0;
				out_v_q    <= 1'b1;
				out_last_q <= 1'b1;
			end
		end
	end

	// Result payload registers.
	always_ff @(posedge clk) begin
		if (push_v) begin
			hold_q <= push_r;
			out_q  <= hold_q;
		end else if (state_q == ST_FLUSH) begin
			out_q <= hold_q;
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign result_valid    = out_v_q;
	assign last            = out_last_q;
	assign depends_on      = out_q.depends_on;
	assign whole_task_sync = out_q.whole_task_sync;
	assign hazard          = out_q.hazard;
	assign is_summary      = out_q.is_summary;
	assign self_conflict   = out_q.self_conflict;
	assign reader_overflow = out_q.reader_overflow;

endmodule

>>> rtl/core/ahs_ram.sv
// ----------------------------------------------------------------------------
// Access hazard scoreboard RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ahs_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> verif/tb_access_hazard_scoreboard.sv
// ----------------------------------------------------------------------------
// Access hazard scoreboard testbench
// Drives read, write, clear and unused-kind requests to the scoreboard, predicts
// every dependency and summary result with a local model of the hazard table,
// and compares each strobed result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_access_hazard_scoreboard;
	import ahs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;

	// One request as driven on the ports.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] task_id;
		logic [5:0] type_id;
		logic       rnd;
		logic       disp;
		logic       fin;
	} req_t;

	// One predicted result with its last marker.
	typedef struct packed {
		res_t res;
		logic last;
	} exp_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [1:0] kind = KIND_READ;
	logic [7:0] task_id = '0;
	logic [5:0] type_id = '0;
	logic       random_access = 1'b0;
	logic       task_random_dispatch = 1'b0;
	logic       last_access = 1'b0;
	logic       result_valid;
	logic [7:0] depends_on;
	logic       whole_task_sync;
	logic [1:0] hazard;
	logic       is_summary;
	logic       self_conflict;
	logic       reader_overflow;
	logic       last;

	req_t pending_reqs[$];
	exp_t expected_results[$];
	int   idle_pct = 24;
	int   mismatches = 0;
	int   cycles = 0;

	// Predictor state.
	bit    m_wvalid[TYPE_COUNT];
	acc_t  m_writer[TYPE_COUNT];
	int    m_rcount[TYPE_COUNT];
	acc_t  m_readers[TYPE_COUNT][READER_SLOTS];
	pend_t m_pend[READ_SLOTS];
	int    m_pcount;
	bit    m_conflict;
	bit    m_overflow;

	access_hazard_scoreboard u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.task_id(task_id), .type_id(type_id), .random_access(random_access),
		.task_random_dispatch(task_random_dispatch), .last_access(last_access),
		.result_valid(result_valid), .depends_on(depends_on),
		.whole_task_sync(whole_task_sync), .hazard(hazard), .is_summary(is_summary),
		.self_conflict(self_conflict), .reader_overflow(reader_overflow), .last(last)
	);

	always #5 clk = ~clk;

	function automatic void clear_table();
		for (int t = 0; t < TYPE_COUNT; t++) begin
			m_wvalid[t] = 1'b0;
			m_rcount[t] = 0;
		end
		m_pcount = 0;
		m_conflict = 1'b0;
		m_overflow = 1'b0;
	endfunction

	function automatic void push_dep(logic [7:0] dep, logic whole, logic [1:0] haz);
		exp_t e;
		e = '0;
		e.res.depends_on = dep;
		e.res.whole_task_sync = whole;
		e.res.hazard = haz;
		expected_results.push_back(e);
	endfunction

	// Works out the results of one accepted request and updates the table.
	function automatic void predict_hazards(req_t r);
		int   n0;
		int   ty;
		acc_t me;
		exp_t e;
		n0 = expected_results.size();
		ty = r.type_id;
		me.task_id = r.task_id;
		me.rnd = r.rnd;
		me.disp = r.disp;
		if (r.kind == KIND_CLEAR) begin
			clear_table();
			return;
		end
		if (r.kind == 2'd3) return;
		if (r.kind == KIND_READ) begin
			if (m_wvalid[ty])
				push_dep(m_writer[ty].task_id, r.disp | r.rnd | m_writer[ty].disp |
					m_writer[ty].rnd, HAZ_RAW);
			if (m_rcount[ty] < READER_SLOTS) begin
				m_readers[ty][m_rcount[ty]] = me;
				m_rcount[ty]++;
			end else
				m_overflow = 1'b1;
			if (m_pcount < READ_SLOTS) begin
				m_pend[m_pcount].type_id = TYPE_W'(ty);
				m_pend[m_pcount].rnd = r.rnd;
				m_pcount++;
			end else
				m_overflow = 1'b1;
		end else begin
			for (int i = 0; i < m_pcount; i++)
				if (m_pend[i].type_id == ty && (r.rnd || m_pend[i].rnd)) m_conflict = 1'b1;
			for (int i = 0; i < m_rcount[ty]; i++)
				if (m_readers[ty][i].task_id != r.task_id)
					push_dep(m_readers[ty][i].task_id, r.disp | r.rnd |
						m_readers[ty][i].disp | m_readers[ty][i].rnd, HAZ_WAR);
			if (m_wvalid[ty])
				push_dep(m_writer[ty].task_id, r.disp | r.rnd | m_writer[ty].disp |
					m_writer[ty].rnd, HAZ_WAW);
			m_wvalid[ty] = 1'b1;
			m_writer[ty] = me;
			m_rcount[ty] = 0;
		end
		if (r.fin) begin
			e = '0;
			e.res.is_summary = 1'b1;
			e.res.self_conflict = m_conflict;
			e.res.reader_overflow = m_overflow;
			expected_results.push_back(e);
			m_pcount = 0;
			m_conflict = 1'b0;
			m_overflow = 1'b0;
		end
		if (expected_results.size() > n0)
			expected_results[expected_results.size() - 1].last = 1'b1;
	endfunction

	function automatic req_t make_req(logic [1:0] k, logic [7:0] t, logic [5:0] ty,
		logic rnd, logic disp, logic fin);
		req_t r;
		r.kind = k; r.task_id = t; r.type_id = ty; r.rnd = rnd; r.disp = disp; r.fin = fin;
		return r;
	endfunction

	// Driver: offers the next pending request unless idling this cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_hazards(make_req(kind, task_id, type_id, random_access,
					task_random_dispatch, last_access));
				void'(pending_reqs.pop_front());
			end
			if ((!start || !busy) && (!start || 1)) begin
				if (start && busy) begin
				end else if (pending_reqs.size() > ((start && !busy) ? 0 : 0) &&
					$urandom_range(99) >= idle_pct) begin
					start <= 1'b1;
					kind <= pending_reqs[0].kind;
					task_id <= pending_reqs[0].task_id;
					type_id <= pending_reqs[0].type_id;
					random_access <= pending_reqs[0].rnd;
					task_random_dispatch <= pending_reqs[0].disp;
					last_access <= pending_reqs[0].fin;
				end else
					start <= 1'b0;
			end
		end
	end

	// Monitor: compares each strobed result with the oldest prediction.
	always @(posedge clk) begin
		exp_t e;
		exp_t got;
		cycles <= cycles + 1;
		if (arst_n && result_valid) begin
			got.res.depends_on = depends_on;
			got.res.whole_task_sync = whole_task_sync;
			got.res.hazard = hazard;
			got.res.is_summary = is_summary;
			got.res.self_conflict = self_conflict;
			got.res.reader_overflow = reader_overflow;
			got.last = last;
			if (expected_results.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("Unexpected result %h", got);
			end else begin
				e = expected_results.pop_front();
				if (e !== got) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) $display("Mismatch: expected %h, got %h", e, got);
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || start || busy || expected_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Adds one well-formed task: a few reads, then writes, the last one final.
	task automatic queue_task_accesses(int ntypes);
		logic [7:0] t;
		logic       disp;
		int         nr;
		int         nw;
		t = $urandom_range(ntypes > 8 ? 255 : 7);
		disp = ($urandom_range(3) == 0);
		nr = $urandom_range(6);
		nw = $urandom_range(3);
		if (nr + nw == 0) nw = 1;
		for (int i = 0; i < nr; i++)
			pending_reqs.push_back(make_req(KIND_READ, t, $urandom_range(ntypes - 1),
				$urandom_range(1), disp, (nw == 0 && i == nr - 1)));
		for (int i = 0; i < nw; i++)
			pending_reqs.push_back(make_req(KIND_WRITE, t, $urandom_range(ntypes - 1),
				$urandom_range(1), disp, i == nw - 1));
	endtask

	initial begin
		req_t r;
		clear_table();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// Directed: plain dependencies, extremes, self conflict, reader overflow, an unused kind, clear.
		pending_reqs.push_back(make_req(KIND_WRITE, 8'd0, 6'd0, 1'b0, 1'b0, 1'b0));
		pending_reqs.push_back(make_req(KIND_READ, 8'd255, 6'd0, 1'b0, 1'b0, 1'b0));
		pending_reqs.push_back(make_req(KIND_WRITE, 8'd255, 6'd0, 1'b1, 1'b0, 1'b1));
		pending_reqs.push_back(make_req(KIND_READ, 8'd1, 6'd63, 1'b0, 1'b1, 1'b1));
		for (int i = 0; i < 10; i++)
			pending_reqs.push_back(make_req(KIND_READ, 8'd2 + i, 6'd5, i[0], 1'b0, 1'b0));
		pending_reqs.push_back(make_req(KIND_WRITE, 8'd3, 6'd5, 1'b0, 1'b0, 1'b1));
		pending_reqs.push_back(make_req(KIND_READ, 8'd7, 6'd5, 1'b0, 1'b0, 1'b0));
		pending_reqs.push_back(make_req(2'd3, 8'd9, 6'd5, 1'b1, 1'b1, 1'b1));
		pending_reqs.push_back(make_req(KIND_CLEAR, 8'd9, 6'd5, 1'b1, 1'b1, 1'b1));
		pending_reqs.push_back(make_req(KIND_WRITE, 8'd170, 6'd42, 1'b0, 1'b0, 1'b1));
		pending_reqs.push_back(make_req(KIND_WRITE, 8'd85, 6'd42, 1'b0, 1'b0, 1'b1));
		// Random: mostly well-formed tasks over a few types, with some noise.
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 24 : (ph == 1) ? 52 : 0;
			while (pending_reqs.size() < 60 + ph * 80) begin
				case ($urandom_range(19))
					0: pending_reqs.push_back(make_req(KIND_CLEAR, $urandom, $urandom,
						$urandom, $urandom, $urandom));
					1, 2: begin
						r = $urandom;
						pending_reqs.push_back(r);
					end
					default: queue_task_accesses($urandom_range(3) == 0 ? 64 : 4);
				endcase
			end
			wait_drained();
		end
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
